// ----- rtl/cjd_pkg.sv -----
// ----------------------------------------------------------------------------
// cjd_pkg - shared constants for the Julian day converter
// Field widths, time constants, reciprocal multipliers for the divisions
// by constants, and the month-length table floor(30.6001 * k).
// ----------------------------------------------------------------------------
package cjd_pkg;

  // Time of day in milliseconds
  localparam logic [26:0] MS_PER_DAY  = 27'd86400000;
  localparam logic [26:0] MS_PER_HOUR = 27'd3600000;
  localparam logic [26:0] MS_PER_MIN  = 27'd60000;

  // Calendar constants
  localparam logic [26:0] DATE_BASE      = 27'd1720997;
  localparam logic [23:0] GREG_FIRST_DAY = 24'd2299161;
  localparam logic [25:0] ALPHA_OFFSET   = 26'd7468865;
  localparam logic [22:0] DAYNUM_MAX     = 23'h7FFFFF;
  localparam logic [15:0] YEAR_MAX       = 16'd16383;

  // Division by a constant D of an N-bit value: q = (x * M) >> S with
  // S = N + clog2(D) and M = ceil(2^S / D); exact for every N-bit x.

  // Year / 25 (used for year/100 and year/400 after a shift)
  localparam int unsigned Q25_N  = 12;
  localparam int unsigned Q25_D  = 25;
  localparam int unsigned Q25_S  = Q25_N + $clog2(Q25_D);
  localparam int unsigned Q25_PW = 2 * Q25_N + 1;
  localparam logic [Q25_N:0] Q25_M =
    (Q25_N + 1)'(((64'd1 << Q25_S) + 64'(Q25_D) - 64'd1) / 64'(Q25_D));

  // Century count for the Gregorian correction
  localparam int unsigned ALPHA_N  = 25;
  localparam int unsigned ALPHA_D  = 146097;
  localparam int unsigned ALPHA_S  = ALPHA_N + $clog2(ALPHA_D);
  localparam int unsigned ALPHA_PW = 2 * ALPHA_N + 1;
  localparam logic [ALPHA_N:0] ALPHA_M =
    (ALPHA_N + 1)'(((64'd1 << ALPHA_S) + 64'(ALPHA_D) - 64'd1) / 64'(ALPHA_D));

  // Year count from the shifted day number
  localparam int unsigned CY_N  = 28;
  localparam int unsigned CY_D  = 7305;
  localparam int unsigned CY_S  = CY_N + $clog2(CY_D);
  localparam int unsigned CY_PW = 2 * CY_N + 1;
  localparam logic [CY_N:0] CY_M =
    (CY_N + 1)'(((64'd1 << CY_S) + 64'(CY_D) - 64'd1) / 64'(CY_D));

  // Month index from the day of the year
  localparam int unsigned EM_N  = 24;
  localparam int unsigned EM_D  = 306001;
  localparam int unsigned EM_S  = EM_N + $clog2(EM_D);
  localparam int unsigned EM_PW = 2 * EM_N + 1;
  localparam logic [EM_N:0] EM_M =
    (EM_N + 1)'(((64'd1 << EM_S) + 64'(EM_D) - 64'd1) / 64'(EM_D));

  // Hours from milliseconds of the day
  localparam int unsigned HR_N  = 27;
  localparam int unsigned HR_D  = 3600000;
  localparam int unsigned HR_S  = HR_N + $clog2(HR_D);
  localparam int unsigned HR_PW = 2 * HR_N + 1;
  localparam logic [HR_N:0] HR_M =
    (HR_N + 1)'(((64'd1 << HR_S) + 64'(HR_D) - 64'd1) / 64'(HR_D));

  // Minutes from milliseconds of the hour
  localparam int unsigned MN_N  = 22;
  localparam int unsigned MN_D  = 60000;
  localparam int unsigned MN_S  = MN_N + $clog2(MN_D);
  localparam int unsigned MN_PW = 2 * MN_N + 1;
  localparam logic [MN_N:0] MN_M =
    (MN_N + 1)'(((64'd1 << MN_S) + 64'(MN_D) - 64'd1) / 64'(MN_D));

  // floor(30.6001 * k)
  function automatic logic [8:0] month_days(input logic [4:0] k);
    logic [8:0] r;
    unique case (k)
      5'd0:    r = 9'd0;
      5'd1:    r = 9'd30;
      5'd2:    r = 9'd61;
      5'd3:    r = 9'd91;
      5'd4:    r = 9'd122;
      5'd5:    r = 9'd153;
      5'd6:    r = 9'd183;
      5'd7:    r = 9'd214;
      5'd8:    r = 9'd244;
      5'd9:    r = 9'd275;
      5'd10:   r = 9'd306;
      5'd11:   r = 9'd336;
      5'd12:   r = 9'd367;
      5'd13:   r = 9'd397;
      5'd14:   r = 9'd428;
      5'd15:   r = 9'd459;
      5'd16:   r = 9'd489;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/cjd_if.sv -----
// ----------------------------------------------------------------------------
// cjd_if - channel interfaces of the Julian day converter
// Request channel (date/time or day number/time) and result channel,
// each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cjd_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [14:0] year;
  logic [3:0]         month;
  logic [4:0]         day;
  logic [4:0]         hour;
  logic [5:0]         minute;
  logic [15:0]        second_ms;
  logic [22:0]        day_number;
  logic [26:0]        time_ms;

  modport source (output valid, mode, year, month, day, hour, minute, second_ms,
                  day_number, time_ms, input ready);
  modport sink   (input valid, mode, year, month, day, hour, minute, second_ms,
                  day_number, time_ms, output ready);
endinterface

interface cjd_out_if;
  logic               valid;
  logic               ready;
  logic [22:0]        out_day_number;
  logic [26:0]        out_time_ms;
  logic signed [14:0] out_year;
  logic [3:0]         out_month;
  logic [4:0]         out_day;
  logic [4:0]         out_hour;
  logic [5:0]         out_minute;
  logic [15:0]        out_second_ms;

  modport source (output valid, out_day_number, out_time_ms, out_year, out_month,
                  out_day, out_hour, out_minute, out_second_ms, input ready);
  modport sink   (input valid, out_day_number, out_time_ms, out_year, out_month,
                  out_day, out_hour, out_minute, out_second_ms, output ready);
endinterface

// ----- rtl/calendar_julian_day_converter_top.sv -----
// ----------------------------------------------------------------------------
// calendar_julian_day_converter_top - calendar date <-> Julian day number
// Eleven-stage pipeline converting a date and time to the day number and
// milliseconds of the day (mode 0), or back to date and time (mode 1).
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : request channel. mode selects the direction; mode 0 reads year,
//           month, day, hour, minute, second_ms; mode 1 reads day_number
//           and time_ms. A transfer happens when valid and ready are high.
//   out_o : result channel, one result per request, in request order. Fields
//           of the other direction read as zero.
//   One request per cycle is taken unless the pipeline is full and
//   stalled. The depth is set by the chain of constant
//   multiplications (reciprocal divides) on the day number path.
//   Each stage holds its item while the stage after it is full and stalled,
//   so empty stages still fill while the receiver holds ready low; ready on
//   in_i drops only once all eleven stages are full.
//   Reset (rst_ni low) empties the pipeline; no state survives otherwise.
// ----------------------------------------------------------------------------
module calendar_julian_day_converter_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  cjd_in_if.sink    in_i,
  cjd_out_if.source out_o
);

  localparam int unsigned NS = 11;

  logic [NS:1] v_q;
  logic [NS:1] en;

  // Stage enables: a stage loads when empty or when its successor moves
  always_comb begin
    en[NS] = !v_q[NS] || out_o.ready;
    for (int k = NS - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k + 1];
    end
  end

  assign in_i.ready = en[1];

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) begin
        v_q[1] <= in_i.valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k - 1];
        end
      end
    end
  end

  // ---------------- stage 1: month shift, time sum, day carry ---------------
  logic               s1_mode_q;
  logic signed [15:0] s1_ym_q, s1_ym_d;
  logic [3:0]         s1_mm_q, s1_mm_d;
  logic [4:0]         s1_d_q;
  logic [26:0]        s1_t0_q, s1_t0_d;
  logic [23:0]        s1_z_q, s1_z_d;
  logic [26:0]        s1_t_q, s1_t_d;
  logic               s1_mlo, s1_car;

  assign s1_mlo  = in_i.month <= 4'd2;
  assign s1_ym_d = {in_i.year[14], in_i.year} - {15'd0, s1_mlo};
  assign s1_mm_d = s1_mlo ? in_i.month + 4'd12 : in_i.month;
  assign s1_t0_d = 27'(in_i.hour) * cjd_pkg::MS_PER_HOUR
                 + 27'(in_i.minute) * cjd_pkg::MS_PER_MIN
                 + 27'(in_i.second_ms);
  assign s1_car  = in_i.time_ms >= cjd_pkg::MS_PER_DAY;
  assign s1_z_d  = {1'b0, in_i.day_number} + {23'd0, s1_car};
  assign s1_t_d  = s1_car ? in_i.time_ms - cjd_pkg::MS_PER_DAY : in_i.time_ms;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_mode_q <= in_i.mode;
      s1_ym_q   <= s1_ym_d;
      s1_mm_q   <= s1_mm_d;
      s1_d_q    <= in_i.day;
      s1_t0_q   <= s1_t0_d;
      s1_z_q    <= s1_z_d;
      s1_t_q    <= s1_t_d;
    end
  end

  // ---------------- stage 2: calendar select, year products ----------------
  logic                          s2_mode_q;
  logic                          s2_greg_q, s2_greg_d;
  logic signed [26:0]            s2_p1461_q, s2_p1461_d;
  logic [cjd_pkg::Q25_PW-1:0]    s2_q100_q, s2_q100_d, s2_q400_q, s2_q400_d;
  logic [3:0]                    s2_mm_q;
  logic [4:0]                    s2_d_q;
  logic                          s2_tcar_q, s2_tcar_d;
  logic [26:0]                   s2_tday_q, s2_tday_d;
  logic                          s2_gz_q, s2_gz_d;
  logic [25:0]                   s2_x26;
  logic [24:0]                   s2_x_q;
  logic [23:0]                   s2_z_q;
  logic [cjd_pkg::HR_PW-1:0]     s2_hprod_q, s2_hprod_d;
  logic [26:0]                   s2_t_q;

  assign s2_greg_d  = (s1_ym_q > 16'sd1582)
                   || (s1_ym_q == 16'sd1582
                       && (s1_mm_q > 4'd10 || (s1_mm_q == 4'd10 && s1_d_q >= 5'd15)));
  assign s2_p1461_d = 27'(s1_ym_q) * 27'sd1461;
  assign s2_q100_d  = cjd_pkg::Q25_PW'(s1_ym_q[13:2])
                    * cjd_pkg::Q25_PW'(cjd_pkg::Q25_M);
  assign s2_q400_d  = cjd_pkg::Q25_PW'(s1_ym_q[13:4])
                    * cjd_pkg::Q25_PW'(cjd_pkg::Q25_M);
  assign s2_tcar_d  = s1_t0_q >= cjd_pkg::MS_PER_DAY;
  assign s2_tday_d  = s2_tcar_d ? s1_t0_q - cjd_pkg::MS_PER_DAY : s1_t0_q;
  assign s2_gz_d    = s1_z_q >= cjd_pkg::GREG_FIRST_DAY;
  assign s2_x26     = {s1_z_q, 2'b00} - cjd_pkg::ALPHA_OFFSET;
  assign s2_hprod_d = cjd_pkg::HR_PW'(s1_t_q) * cjd_pkg::HR_PW'(cjd_pkg::HR_M);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_mode_q  <= s1_mode_q;
      s2_greg_q  <= s2_greg_d;
      s2_p1461_q <= s2_p1461_d;
      s2_q100_q  <= s2_q100_d;
      s2_q400_q  <= s2_q400_d;
      s2_mm_q    <= s1_mm_q;
      s2_d_q     <= s1_d_q;
      s2_tcar_q  <= s2_tcar_d;
      s2_tday_q  <= s2_tday_d;
      s2_gz_q    <= s2_gz_d;
      s2_x_q     <= s2_x26[24:0];
      s2_z_q     <= s1_z_q;
      s2_hprod_q <= s2_hprod_d;
      s2_t_q     <= s1_t_q;
    end
  end

  // ---------------- stage 3: correction, base sum, alpha product -----------
  logic                          s3_mode_q;
  logic [15:0]                   s3_corr_q, s3_corr_d;
  logic signed [26:0]            s3_p4;
  logic [26:0]                   s3_base_q, s3_base_d;
  logic [26:0]                   s3_tday_q;
  logic [cjd_pkg::ALPHA_PW-1:0]  s3_aprod_q, s3_aprod_d;
  logic                          s3_gz_q;
  logic [23:0]                   s3_z_q;
  logic [4:0]                    s3_hour_q;
  logic [26:0]                   s3_t_q;

  assign s3_p4      = s2_p1461_q >>> 2;
  assign s3_corr_d  = s2_greg_q
                    ? 16'(s2_q400_q[cjd_pkg::Q25_S +: 8]) - 16'(s2_q100_q[cjd_pkg::Q25_S +: 8])
                    : 16'hFFFE;
  assign s3_base_d  = 27'(s3_p4)
                    + 27'(cjd_pkg::month_days(5'(s2_mm_q) + 5'd1))
                    + 27'(s2_d_q) + cjd_pkg::DATE_BASE + 27'(s2_tcar_q);
  assign s3_aprod_d = cjd_pkg::ALPHA_PW'(s2_x_q) * cjd_pkg::ALPHA_PW'(cjd_pkg::ALPHA_M);

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_mode_q  <= s2_mode_q;
      s3_corr_q  <= s3_corr_d;
      s3_base_q  <= s3_base_d;
      s3_tday_q  <= s2_tday_q;
      s3_aprod_q <= s3_aprod_d;
      s3_gz_q    <= s2_gz_q;
      s3_z_q     <= s2_z_q;
      s3_hour_q  <= s2_hprod_q[cjd_pkg::HR_S +: 5];
      s3_t_q     <= s2_t_q;
    end
  end

  // ---------------- stage 4: day number sum, shifted day, hour remainder ---
  logic        s4_mode_q;
  logic [26:0] s4_n_q, s4_n_d;
  logic [26:0] s4_tday_q;
  logic [7:0]  s4_alpha;
  logic [23:0] s4_a;
  logic [23:0] s4_b_q, s4_b_d;
  logic [21:0] s4_rem_q, s4_rem_d;
  logic [26:0] s4_hms;
  logic [4:0]  s4_hour_q;

  assign s4_n_d   = s3_base_q + {{11{s3_corr_q[15]}}, s3_corr_q};
  assign s4_alpha = s3_aprod_q[cjd_pkg::ALPHA_S +: 8];
  assign s4_a     = s3_gz_q ? s3_z_q + 24'd1 + 24'(s4_alpha) - 24'(s4_alpha[7:2]) : s3_z_q;
  assign s4_b_d   = s4_a + 24'd1524;
  assign s4_hms   = 27'(s3_hour_q) * cjd_pkg::MS_PER_HOUR;
  assign s4_rem_d = 22'(s3_t_q - s4_hms);

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s4_mode_q <= s3_mode_q;
      s4_n_q    <= s4_n_d;
      s4_tday_q <= s3_tday_q;
      s4_b_q    <= s4_b_d;
      s4_rem_q  <= s4_rem_d;
      s4_hour_q <= s3_hour_q;
    end
  end

  // ---------------- stage 5: saturate, year argument, minute product -------
  logic                       s5_mode_q;
  logic [22:0]                s5_dn_q, s5_dn_d;
  logic [26:0]                s5_tday_q;
  logic [27:0]                s5_y_q, s5_y_d;
  logic [23:0]                s5_b_q;
  logic [cjd_pkg::MN_PW-1:0]  s5_mprod_q, s5_mprod_d;
  logic [21:0]                s5_rem_q;
  logic [4:0]                 s5_hour_q;

  always_comb begin
    if (s4_n_q[26]) begin
      s5_dn_d = 23'd0;
    end else if (s4_n_q > 27'(cjd_pkg::DAYNUM_MAX)) begin
      s5_dn_d = cjd_pkg::DAYNUM_MAX;
    end else begin
      s5_dn_d = s4_n_q[22:0];
    end
  end

  assign s5_y_d     = 28'(s4_b_q) * 28'd20 - 28'd2442;
  assign s5_mprod_d = cjd_pkg::MN_PW'(s4_rem_q) * cjd_pkg::MN_PW'(cjd_pkg::MN_M);

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s5_mode_q  <= s4_mode_q;
      s5_dn_q    <= s5_dn_d;
      s5_tday_q  <= s4_tday_q;
      s5_y_q     <= s5_y_d;
      s5_b_q     <= s4_b_q;
      s5_mprod_q <= s5_mprod_d;
      s5_rem_q   <= s4_rem_q;
      s5_hour_q  <= s4_hour_q;
    end
  end

  // ---------------- stage 6: year product, minute and millisecond ----------
  logic                       s6_mode_q;
  logic [22:0]                s6_dn_q;
  logic [26:0]                s6_tday_q;
  logic [cjd_pkg::CY_PW-1:0]  s6_cprod_q, s6_cprod_d;
  logic [23:0]                s6_b_q;
  logic [5:0]                 s6_min_d, s6_min_q;
  logic [21:0]                s6_mms;
  logic [15:0]                s6_msec_q, s6_msec_d;
  logic [4:0]                 s6_hour_q;

  assign s6_cprod_d = cjd_pkg::CY_PW'(s5_y_q) * cjd_pkg::CY_PW'(cjd_pkg::CY_M);
  assign s6_min_d   = s5_mprod_q[cjd_pkg::MN_S +: 6];
  assign s6_mms     = 22'(s6_min_d) * 22'(cjd_pkg::MS_PER_MIN);
  assign s6_msec_d  = 16'(s5_rem_q - s6_mms);

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s6_mode_q  <= s5_mode_q;
      s6_dn_q    <= s5_dn_q;
      s6_tday_q  <= s5_tday_q;
      s6_cprod_q <= s6_cprod_d;
      s6_b_q     <= s5_b_q;
      s6_min_q   <= s6_min_d;
      s6_msec_q  <= s6_msec_d;
      s6_hour_q  <= s5_hour_q;
    end
  end

  // ---------------- stage 7: year count, day of year -----------------------
  logic        s7_mode_q;
  logic [22:0] s7_dn_q;
  logic [26:0] s7_tday_q;
  logic [14:0] s7_c_d, s7_c_q;
  logic [25:0] s7_cdays;
  logic [9:0]  s7_dd_q, s7_dd_d;
  logic [5:0]  s7_min_q;
  logic [15:0] s7_msec_q;
  logic [4:0]  s7_hour_q;

  assign s7_c_d    = s6_cprod_q[cjd_pkg::CY_S +: 15];
  assign s7_cdays  = (26'(s7_c_d) * 26'd1461) >> 2;
  assign s7_dd_d   = 10'(s6_b_q - s7_cdays[23:0]);

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      s7_mode_q <= s6_mode_q;
      s7_dn_q   <= s6_dn_q;
      s7_tday_q <= s6_tday_q;
      s7_c_q    <= s7_c_d;
      s7_dd_q   <= s7_dd_d;
      s7_min_q  <= s6_min_q;
      s7_msec_q <= s6_msec_q;
      s7_hour_q <= s6_hour_q;
    end
  end

  // ---------------- stage 8: scale day of year -----------------------------
  logic        s8_mode_q;
  logic [22:0] s8_dn_q;
  logic [26:0] s8_tday_q;
  logic [23:0] s8_x_q;
  logic [14:0] s8_c_q;
  logic [9:0]  s8_dd_q;
  logic [5:0]  s8_min_q;
  logic [15:0] s8_msec_q;
  logic [4:0]  s8_hour_q;

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      s8_mode_q <= s7_mode_q;
      s8_dn_q   <= s7_dn_q;
      s8_tday_q <= s7_tday_q;
      s8_x_q    <= 24'(s7_dd_q) * 24'd10000;
      s8_c_q    <= s7_c_q;
      s8_dd_q   <= s7_dd_q;
      s8_min_q  <= s7_min_q;
      s8_msec_q <= s7_msec_q;
      s8_hour_q <= s7_hour_q;
    end
  end

  // ---------------- stage 9: month index product ---------------------------
  logic                       s9_mode_q;
  logic [22:0]                s9_dn_q;
  logic [26:0]                s9_tday_q;
  logic [cjd_pkg::EM_PW-1:0]  s9_eprod_q;
  logic [14:0]                s9_c_q;
  logic [9:0]                 s9_dd_q;
  logic [5:0]                 s9_min_q;
  logic [15:0]                s9_msec_q;
  logic [4:0]                 s9_hour_q;

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      s9_mode_q  <= s8_mode_q;
      s9_dn_q    <= s8_dn_q;
      s9_tday_q  <= s8_tday_q;
      s9_eprod_q <= cjd_pkg::EM_PW'(s8_x_q) * cjd_pkg::EM_PW'(cjd_pkg::EM_M);
      s9_c_q     <= s8_c_q;
      s9_dd_q    <= s8_dd_q;
      s9_min_q   <= s8_min_q;
      s9_msec_q  <= s8_msec_q;
      s9_hour_q  <= s8_hour_q;
    end
  end

  // ---------------- stage 10: day, month, raw year -------------------------
  logic               s10_mode_q;
  logic [22:0]        s10_dn_q;
  logic [26:0]        s10_tday_q;
  logic [4:0]         s10_e;
  logic [3:0]         s10_m1, s10_mon_d, s10_mon_q;
  logic [4:0]         s10_day_d, s10_day_q;
  logic signed [15:0] s10_yr_d, s10_yr_q;
  logic [5:0]         s10_min_q;
  logic [15:0]        s10_msec_q;
  logic [4:0]         s10_hour_q;

  assign s10_e     = s9_eprod_q[cjd_pkg::EM_S +: 5];
  assign s10_day_d = 5'(s9_dd_q - 10'(cjd_pkg::month_days(s10_e)));
  assign s10_m1    = 4'(s10_e - 5'd1);
  assign s10_mon_d = (s10_m1 > 4'd12) ? s10_m1 - 4'd12 : s10_m1;
  assign s10_yr_d  = signed'(16'(s9_c_q) - 16'd4716 + {15'd0, s10_mon_d <= 4'd2});

  always_ff @(posedge clk_i) begin
    if (en[10]) begin
      s10_mode_q <= s9_mode_q;
      s10_dn_q   <= s9_dn_q;
      s10_tday_q <= s9_tday_q;
      s10_mon_q  <= s10_mon_d;
      s10_day_q  <= s10_day_d;
      s10_yr_q   <= s10_yr_d;
      s10_min_q  <= s9_min_q;
      s10_msec_q <= s9_msec_q;
      s10_hour_q <= s9_hour_q;
    end
  end

  // ---------------- stage 11: year fix-up and output register --------------
  logic               s11_mode_q;
  logic signed [15:0] s11_yr;
  logic [22:0]        s11_dn_q;
  logic [26:0]        s11_tms_q;
  logic [14:0]        s11_year_q;
  logic [3:0]         s11_mon_q;
  logic [4:0]         s11_day_q;
  logic [4:0]         s11_hour_q;
  logic [5:0]         s11_min_q;
  logic [15:0]        s11_msec_q;

  // Skip year zero, clamp the top
  always_comb begin
    if (s10_yr_q < 16'sd1) begin
      s11_yr = s10_yr_q - 16'sd1;
    end else if (s10_yr_q > signed'(cjd_pkg::YEAR_MAX)) begin
      s11_yr = signed'(cjd_pkg::YEAR_MAX);
    end else begin
      s11_yr = s10_yr_q;
    end
  end

  // Zero the fields of the unused direction
  always_ff @(posedge clk_i) begin
    if (en[11]) begin
      s11_mode_q <= s10_mode_q;
      s11_dn_q   <= s10_mode_q ? 23'd0 : s10_dn_q;
      s11_tms_q  <= s10_mode_q ? 27'd0 : s10_tday_q;
      s11_year_q <= s10_mode_q ? s11_yr[14:0] : 15'd0;
      s11_mon_q  <= s10_mode_q ? s10_mon_q : 4'd0;
      s11_day_q  <= s10_mode_q ? s10_day_q : 5'd0;
      s11_hour_q <= s10_mode_q ? s10_hour_q : 5'd0;
      s11_min_q  <= s10_mode_q ? s10_min_q : 6'd0;
      s11_msec_q <= s10_mode_q ? s10_msec_q : 16'd0;
    end
  end

  assign out_o.valid          = v_q[NS];
  assign out_o.out_day_number = s11_dn_q;
  assign out_o.out_time_ms    = s11_tms_q;
  assign out_o.out_year       = signed'(s11_year_q);
  assign out_o.out_month      = s11_mon_q;
  assign out_o.out_day        = s11_day_q;
  assign out_o.out_hour       = s11_hour_q;
  assign out_o.out_minute     = s11_min_q;
  assign out_o.out_second_ms  = s11_msec_q;

`ifndef ASSERT_OFF
  // Date results carry no day number
  a_mode1_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && s11_mode_q |-> out_o.out_day_number == 23'd0
                                  && out_o.out_time_ms == 27'd0)
    else $error("date result with nonzero day number fields");

  // Day number results carry no date
  a_mode0_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !s11_mode_q |-> out_o.out_month == 4'd0 && out_o.out_day == 5'd0
                                   && out_o.out_year == 15'sd0)
    else $error("day number result with nonzero date fields");

  // Derived month always lands in range
  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && s11_mode_q |-> out_o.out_month >= 4'd1 && out_o.out_month <= 4'd12)
    else $error("month out of range");

  // A blocked first stage keeps its item
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] && !en[1] |=> v_q[1] && $stable(s1_z_q) && $stable(s1_ym_q))
    else $error("stalled first stage lost its item");
`endif

endmodule

// ----- test/calendar_julian_day_converter_top_tb.sv -----
// ----------------------------------------------------------------------------
// calendar_julian_day_converter_top_tb - converter check in both directions
// Drives dates and day numbers through the request channel with random idle
// cycles on both sides, predicts each result in exact integer arithmetic and
// compares it field by field with the result channel, in order.
// ----------------------------------------------------------------------------
module calendar_julian_day_converter_top_tb;

  typedef struct packed {
    logic [22:0]        day_number;
    logic [26:0]        time_ms;
    logic signed [14:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [15:0]        second_ms;
  } date_result_t;

  localparam longint MsDay  = 86400000;
  localparam longint MsHour = 3600000;
  localparam longint MsMin  = 60000;
  localparam int     NumRandom = 1630;
  localparam longint CycleLimit = 200000;

  // Compute the converted date or day number for one request
  function automatic date_result_t convert_date(input logic mode,
      input logic signed [14:0] yr_in, input logic [3:0] mon_in,
      input logic [4:0] day_in, input logic [4:0] hr_in, input logic [5:0] min_in,
      input logic [15:0] ms_in, input logic [22:0] dn_in, input logic [26:0] tm_in);
    date_result_t r;
    longint y, m, d, corr, n, t, z, a, b, c, dd, e, mon, yr, alpha, rem;
    r = '0;
    if (!mode) begin
      y = yr_in; m = mon_in; d = day_in; corr = -2;
      if (m <= 2) begin
        m += 12; y -= 1;
      end
      if (y > 1582 || (y == 1582 && (m > 10 || (m == 10 && d >= 15))))
        corr = y / 400 - y / 100;
      a = 1461 * y;
      b = a / 4;
      if (a % 4 != 0 && a < 0) b -= 1;
      n = b + (306001 * (m + 1)) / 10000 + corr + d + 1720997;
      t = hr_in * MsHour + min_in * MsMin + ms_in;
      n += t / MsDay;
      t %= MsDay;
      if (n < 0) n = 0;
      if (n > 8388607) n = 8388607;
      r.day_number = n[22:0];
      r.time_ms = t[26:0];
    end else begin
      z = dn_in; t = tm_in;
      z += t / MsDay;
      t %= MsDay;
      a = z;
      if (z >= 2299161) begin
        alpha = (4 * z - 7468865) / 146097;
        a = z + 1 + alpha - alpha / 4;
      end
      b = a + 1524;
      c = (20 * b - 2442) / 7305;
      dd = b - (1461 * c) / 4;
      e = (10000 * dd) / 306001;
      mon = e - 1;
      if (mon > 12) mon -= 12;
      yr = c - 4716;
      if (mon <= 2) yr += 1;
      if (yr < 1) yr -= 1;
      if (yr > 16383) yr = 16383;
      r.year = yr[14:0];
      r.month = mon[3:0];
      d = dd - (306001 * e) / 10000;
      r.day = d[4:0];
      n = t / MsHour;
      r.hour = n[4:0];
      rem = t % MsHour;
      n = rem / MsMin;
      r.minute = n[5:0];
      n = rem % MsMin;
      r.second_ms = n[15:0];
    end
    return r;
  endfunction

  // Hold expected conversions in request order and check results against them
  class conversion_board;
    date_result_t pending[$];
    int errors;

    function void note_request(date_result_t r);
      pending.push_back(r);
    endfunction

    function void check_result(date_result_t got);
      date_result_t exp;
      if (pending.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.day_number !== exp.day_number) begin
        $error("out_day_number: expected %0d, got %0d", exp.day_number, got.day_number);
        errors++;
      end
      if (got.time_ms !== exp.time_ms) begin
        $error("out_time_ms: expected %0d, got %0d", exp.time_ms, got.time_ms);
        errors++;
      end
      if (got.year !== exp.year) begin
        $error("out_year: expected %0d, got %0d", exp.year, got.year);
        errors++;
      end
      if (got.month !== exp.month) begin
        $error("out_month: expected %0d, got %0d", exp.month, got.month);
        errors++;
      end
      if (got.day !== exp.day) begin
        $error("out_day: expected %0d, got %0d", exp.day, got.day);
        errors++;
      end
      if (got.hour !== exp.hour) begin
        $error("out_hour: expected %0d, got %0d", exp.hour, got.hour);
        errors++;
      end
      if (got.minute !== exp.minute) begin
        $error("out_minute: expected %0d, got %0d", exp.minute, got.minute);
        errors++;
      end
      if (got.second_ms !== exp.second_ms) begin
        $error("out_second_ms: expected %0d, got %0d", exp.second_ms, got.second_ms);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic idle_free;
  longint cycle_cnt = 0;
  conversion_board board;

  cjd_in_if  req_if ();
  cjd_out_if res_if ();

  calendar_julian_day_converter_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if.sink),
    .out_o  (res_if.source)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort on a hung pipeline
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Toggle ready at random, outside the stall-free stretch
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= idle_free ? 1'b1 : ($urandom_range(99) >= 13);
    end
  end

  // Check each result transfer
  always @(posedge clk_i) begin
    date_result_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.day_number = res_if.out_day_number;
      got.time_ms    = res_if.out_time_ms;
      got.year       = res_if.out_year;
      got.month      = res_if.out_month;
      got.day        = res_if.out_day;
      got.hour       = res_if.out_hour;
      got.minute     = res_if.out_minute;
      got.second_ms  = res_if.out_second_ms;
      board.check_result(got);
    end
  end

  // Present one request and hold it until the transfer
  task automatic send_request(input logic mode, input logic signed [14:0] yr,
      input logic [3:0] mon, input logic [4:0] dy, input logic [4:0] hr,
      input logic [5:0] mi, input logic [15:0] ms, input logic [22:0] dn,
      input logic [26:0] tm);
    while (!idle_free && $urandom_range(99) < 13) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.mode       <= mode;
    req_if.year       <= yr;
    req_if.month      <= mon;
    req_if.day        <= dy;
    req_if.hour       <= hr;
    req_if.minute     <= mi;
    req_if.second_ms  <= ms;
    req_if.day_number <= dn;
    req_if.time_ms    <= tm;
    do @(posedge clk_i); while (!req_if.ready);
    board.note_request(convert_date(mode, yr, mon, dy, hr, mi, ms, dn, tm));
  endtask

  task automatic send_date(input int yr, input int mon, input int dy, input int hr,
      input int mi, input int ms);
    send_request(1'b0, yr[14:0], mon[3:0], dy[4:0], hr[4:0], mi[5:0], ms[15:0],
                 23'($urandom), 27'($urandom));
  endtask

  task automatic send_daynum(input int dn, input int tm);
    send_request(1'b1, 15'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
                 6'($urandom), 16'($urandom), dn[22:0], tm[26:0]);
  endtask

  // Send one random request, mostly in range, sometimes raw bits
  task automatic send_random();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40)
      send_date($urandom_range(14711) - 4712, $urandom_range(12, 1),
                $urandom_range(31, 1), $urandom_range(23), $urandom_range(59),
                $urandom_range(59999));
    else if (pick < 48)
      send_date(1582, $urandom_range(11, 9), $urandom_range(31, 1),
                $urandom_range(23), $urandom_range(59), $urandom_range(59999));
    else if (pick < 80)
      send_daynum($urandom_range(5373484), $urandom_range(86399999));
    else if (pick < 86)
      send_daynum($urandom_range(2299171, 2299151), $urandom_range(86399999));
    else if (pick < 93)
      send_date($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    else
      send_daynum($urandom, $urandom);
  endtask

  initial begin
    board        = new();
    idle_free    = 1'b0;
    rst_ni       = 1'b0;
    req_if.valid = 1'b0;
    req_if.mode  = 1'b0;
    req_if.year  = '0;
    req_if.month = '0;
    req_if.day   = '0;
    req_if.hour  = '0;
    req_if.minute     = '0;
    req_if.second_ms  = '0;
    req_if.day_number = '0;
    req_if.time_ms    = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: range ends, calendar switch, month and day wrap, time carry
    send_date(-4712, 1, 1, 12, 0, 0);
    send_date(9999, 12, 31, 23, 59, 59999);
    send_date(1582, 10, 4, 0, 0, 0);
    send_date(1582, 10, 15, 0, 0, 0);
    send_date(1582, 10, 14, 0, 0, 0);
    send_date(2000, 2, 29, 6, 30, 1234);
    send_date(1900, 0, 0, 0, 0, 0);
    send_date(-1, 15, 31, 31, 63, 65535);
    send_date(-16384, 1, 1, 0, 0, 0);
    send_date(16383, 15, 31, 31, 63, 65535);
    send_date(0, 3, 1, 24, 0, 0);
    send_daynum(0, 0);
    send_daynum(5373484, 86399999);
    send_daynum(2299160, 0);
    send_daynum(2299161, 0);
    send_daynum(1721423, 43200000);
    send_daynum(1721424, 0);
    send_daynum(2451544, 86400000);
    send_daynum(8388607, 134217727);
    send_daynum(2459000, 3599999);

    // Wait for the pipeline to drain before the random part
    req_if.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);

    for (int i = 0; i < NumRandom; i++) begin
      idle_free = (i >= 600 && i < 900);
      send_random();
    end
    req_if.valid <= 1'b0;
    idle_free = 1'b0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
